>>> hw/rtl/circular_deque_defines.svh
// Assertion macros shared by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define CDQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("circular_deque: check failed");
// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define CDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("circular_deque: check failed");
`else
`define CDQ_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define CDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/cdq_pkg.sv
// Package with the shared types and constants of the circular deque.
`timescale 1ns / 1ps
`default_nettype none
package cdq_pkg;

  localparam int MAX_DEPTH_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int CAP_W    = 5;
  localparam int CAP_RST  = 16;
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

endpackage
`default_nettype wire

>>> hw/rtl/cdq_in_if.sv
// Command channel of the circular deque.
`timescale 1ns / 1ps
`default_nettype none
interface cdq_in_if;
  import cdq_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cdq_out_if.sv
// Result channel of the circular deque.
`timescale 1ns / 1ps
`default_nettype none
interface cdq_out_if;
  import cdq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic signed [RESULT_W-1:0] front_value;
  logic signed [RESULT_W-1:0] rear_value;
  logic                       is_empty;
  logic                       is_full;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cdq_ring.sv
// Ring store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module cdq_ring #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/circular_deque.sv
// Top level of the circular deque: pointer control, ring store and result register.
// Result path: an accepted item passes the READ state, then the LOAD state, which
// loads the result register once it is free or being drained.
// Items: taken only while idle; the two read ports of the ring store are read
// once per item after the pointers settle, and the next item waits for that read.
// Reset: asynchronous, active low; empties the deque; capacity 16, at most MAX_DEPTH.
// The ring store is not cleared; only slots that hold entries reach the result.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_defines.svh"
module circular_deque #(
  parameter int MAX_DEPTH  = cdq_pkg::MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [cdq_pkg::CAP_W-1:0] cfg_wdata_i,
  cdq_in_if.sink                         req_i,
  cdq_out_if.source                      rsp_o
);
  import cdq_pkg::*;

  // Slot index and entry count widths follow from the ring depth.
  localparam int IdxW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CntW   = $clog2(MAX_DEPTH + 1);
  localparam int CapRst = (CAP_RST > MAX_DEPTH) ? MAX_DEPTH : CAP_RST;

  // Map the written capacity into 1..MAX_DEPTH.
  function automatic logic [CntW-1:0] eff_cap(logic [CAP_W-1:0] c);
    if (c == '0) begin
      return CntW'(1);
    end else if (32'(c) > MAX_DEPTH) begin
      return CntW'(MAX_DEPTH);
    end
    return CntW'(c);
  endfunction

  // Advance an index, wrapping at the capacity in use.
  function automatic logic [IdxW-1:0] step_up(logic [IdxW-1:0] i, logic [CntW-1:0] c);
    logic [CntW:0] nxt;
    nxt = (CntW + 1)'(i) + 1'b1;
    if (nxt >= (CntW + 1)'(c)) begin
      return '0;
    end
    return IdxW'(nxt);
  endfunction

  // Step an index back, wrapping to the last slot in use.
  function automatic logic [IdxW-1:0] step_down(logic [IdxW-1:0] i, logic [CntW-1:0] c);
    if (i == '0) begin
      return IdxW'(c - 1'b1);
    end
    return i - 1'b1;
  endfunction

  // Control state
  state_e          state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;   // slot of the front entry
  logic [IdxW-1:0] tail_q, tail_d;   // slot after the rear entry
  logic [CntW-1:0] occ_q, occ_d;     // entries held
  logic [CntW-1:0] cap_q;            // capacity in use, already clamped
  logic            ok_q, ok_d;       // outcome of the item in flight
  logic            out_valid_q, out_valid_d;

  // Result register payload
  logic                       out_ok_q;
  logic signed [RESULT_W-1:0] out_front_q;
  logic signed [RESULT_W-1:0] out_rear_q;
  logic                       out_empty_q;
  logic                       out_full_q;

  // Handshake and memory strobes
  logic                  req_fire;
  logic                  rsp_fire;
  logic                  load_out;
  logic                  is_push;
  logic                  push_ok;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic                  mem_re;
  logic [IdxW-1:0]       rear_idx;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] front_data;
  logic [DATA_WIDTH-1:0] rear_data;
  cmd_e                  cmd;

  assign cmd       = cmd_e'(req_i.cmd);
  assign push_data = DATA_WIDTH'(req_i.value);
  assign req_fire  = req_i.valid && req_i.ready;
  assign rsp_fire  = out_valid_q && rsp_o.ready;
  assign is_push   = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
  assign push_ok   = req_fire && ok_d && is_push && !cfg_we_i;

  // Take a new item only while idle; a waiting result does not hold it back,
  // the output register parts the two sides.
  assign req_i.ready = (state_q == ST_IDLE);

  // Rear slot follows from the settled tail pointer.
  assign rear_idx = step_down(tail_q, cap_q);
  assign mem_re   = (state_q == ST_READ);

  // Next state, pointer update and memory write.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    load_out    = 1'b0;

    if (rsp_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          ok_d    = 1'b0;
          state_d = ST_READ;
          unique case (cmd)
            CMD_PUSH_FRONT: begin
              if (occ_q < cap_q) begin
                head_d    = step_down(head_q, cap_q);
                mem_we    = 1'b1;
                mem_waddr = head_d;
                occ_d     = occ_q + 1'b1;
                ok_d      = 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              if (occ_q < cap_q) begin
                mem_we    = 1'b1;
                mem_waddr = tail_q;
                tail_d    = step_up(tail_q, cap_q);
                occ_d     = occ_q + 1'b1;
                ok_d      = 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (occ_q != '0) begin
                head_d = step_up(head_q, cap_q);
                occ_d  = occ_q - 1'b1;
                ok_d   = 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (occ_q != '0) begin
                tail_d = step_down(tail_q, cap_q);
                occ_d  = occ_q - 1'b1;
                ok_d   = 1'b1;
              end
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        // reads of front and rear slots are issued this cycle
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || rsp_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Capacity write empties the deque; user must write only while idle (unchecked).
    if (cfg_we_i) begin
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      cap_q       <= CntW'(CapRst);
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= eff_cap(cfg_wdata_i);
      end
    end
  end

  // Result payload: -1 in both value fields when the deque is empty.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ok_q    <= ok_q;
      out_empty_q <= (occ_q == '0);
      out_full_q  <= (occ_q >= cap_q);
      if (occ_q == '0) begin
        out_front_q <= '1;
        out_rear_q  <= '1;
      end else begin
        out_front_q <= RESULT_W'(front_data);
        out_rear_q  <= RESULT_W'(rear_data);
      end
    end
  end

  cdq_ring #(
    .DEPTH (MAX_DEPTH),
    .WIDTH (DATA_WIDTH),
    .AW    (IdxW)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (push_data),
    .re_i      (mem_re),
    .raddr_a_i (head_q),
    .raddr_b_i (rear_idx),
    .rdata_a_o (front_data),
    .rdata_b_o (rear_data)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ok          = out_ok_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.rear_value  = out_rear_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.is_full     = out_full_q;

  // The entry count never exceeds the capacity in use.
  `CDQ_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= cap_q)
  // A successful push raises the entry count by one.
  `CDQ_ASSERT_NEXT(a_push_count, clk_i, rst_ni, push_ok, occ_q == $past(occ_q) + 1'b1)
  // A new result only appears from the load step.
  `CDQ_ASSERT_NOW(a_out_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_LOAD)

endmodule
`default_nettype wire
